@@ sv/cpib_pkg.sv @@
// Package with the shared constants, word types and symbol function of the palette builder.
`timescale 1ns / 1ps

package cpib_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
    localparam int OUT_IDX_W       = 4;
    localparam int SYM_W           = 7;

    localparam logic [SYM_W-1:0] SYM_SPACE  = 7'd32;
    localparam logic [SYM_W-1:0] SYM_BASE   = 7'd64;
    localparam logic [SYM_W-1:0] SYM_NONE   = 7'd0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    localparam int PIXEL_W = $bits(t_pixel);

    typedef struct packed {
        logic [OUT_IDX_W-1:0] palette_index;
        logic [SYM_W-1:0]     symbol_code;
        logic                 newly_added;
        logic                 table_full_error;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } t_dp_status;

    // Space for index 0, then 'A', 'B', ... for the indices after it.
    function automatic logic [SYM_W-1:0] symbol_of(input logic [CNT_W-1:0] idx);
        logic [SYM_W-1:0] sym;
        if (idx == '0) begin
            sym = SYM_SPACE;
        end else begin
            sym = SYM_BASE + SYM_W'(idx);
        end
        return sym;
    endfunction

endpackage

@@ sv/cpib_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cpib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cpib_ctrl.sv @@
// Controller state machine that sequences the palette scan and the result hand-off.
`timescale 1ns / 1ps

module cpib_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cpib_pkg::t_dp_status i_status,
    output cpib_pkg::t_dp_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state;
    logic n_state;
    logic done;

    assign done = i_status.hit || i_status.exhausted;

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // A finished search waits here until the output register can take the word.
                if (done) begin
                    if (i_status.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/cpib_dp.sv @@
// Datapath: pixel key, scan counter, palette RAM, entry count and output register.
`timescale 1ns / 1ps

module cpib_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cpib_pkg::t_pixel     i_pixel,
    input  cpib_pkg::t_dp_cmd    i_cmd,
    output cpib_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cpib_pkg::t_result    o_out_data
);

    cpib_pkg::t_pixel              r_key;
    logic [cpib_pkg::CNT_W-1:0]    r_scan_idx;
    logic [cpib_pkg::CNT_W-1:0]    n_scan_idx;
    logic [cpib_pkg::CNT_W-1:0]    r_used_count;
    logic [cpib_pkg::CNT_W-1:0]    n_used_count;
    logic                          r_pend;
    logic                          n_pend;
    logic [cpib_pkg::IDX_W-1:0]    r_pend_idx;
    logic [cpib_pkg::IDX_W-1:0]    n_pend_idx;
    logic                          r_out_valid;
    logic                          n_out_valid;
    cpib_pkg::t_result             r_out_data;
    cpib_pkg::t_result             n_out_data;

    logic                          issue;
    logic                          rd_en;
    logic                          wr_en;
    logic                          has_room;
    logic [cpib_pkg::PIXEL_W-1:0]  rd_data;
    logic [cpib_pkg::CNT_W-1:0]    res_idx;

    assign issue    = r_scan_idx < r_used_count;
    assign rd_en    = i_cmd.step && issue;
    assign has_room = r_used_count < cpib_pkg::CNT_W'(cpib_pkg::PALETTE_ENTRIES);
    assign wr_en    = i_cmd.finish && !o_status.hit && has_room;

    // The RAM word read last cycle belongs to entry r_pend_idx.
    assign o_status.hit       = r_pend && (rd_data == r_key);
    assign o_status.exhausted = !r_pend && !issue;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign res_idx = o_status.hit ? cpib_pkg::CNT_W'(r_pend_idx) : r_used_count;

    cpib_ram #(
        .WIDTH(cpib_pkg::PIXEL_W),
        .DEPTH(cpib_pkg::PALETTE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_used_count[cpib_pkg::IDX_W-1:0]),
        .i_wdata(r_key),
        .i_re   (rd_en),
        .i_raddr(r_scan_idx[cpib_pkg::IDX_W-1:0]),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_scan_idx   = r_scan_idx;
        n_used_count = r_used_count;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        if (i_cmd.start) begin
            n_scan_idx = '0;
            n_pend     = 1'b0;
        end else if (i_cmd.step) begin
            n_pend     = issue;
            n_pend_idx = r_scan_idx[cpib_pkg::IDX_W-1:0];
            if (issue) begin
                n_scan_idx = r_scan_idx + cpib_pkg::CNT_W'(1);
            end
        end

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            if (o_status.hit || has_room) begin
                n_out_data.palette_index    = cpib_pkg::OUT_IDX_W'(res_idx);
                n_out_data.symbol_code      = cpib_pkg::symbol_of(res_idx);
                n_out_data.newly_added      = !o_status.hit;
                n_out_data.table_full_error = 1'b0;
            end else begin
                n_out_data.palette_index    = '0;
                n_out_data.symbol_code      = cpib_pkg::SYM_NONE;
                n_out_data.newly_added      = 1'b0;
                n_out_data.table_full_error = 1'b1;
            end
            if (wr_en) begin
                n_used_count = r_used_count + cpib_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_count <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used_count <= n_used_count;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_pixel;
        end
        r_scan_idx <= n_scan_idx;
        r_pend_idx <= n_pend_idx;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ sv/color_palette_index_builder.sv @@
// Top level of the learned palette lookup with insert.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_ready   i_in_data  (red, green, blue)
//   out      output     o_out_valid / i_out_ready o_out_data (index, symbol, flags)
//
// On a miss the scan reads every used entry before the result is loaded.
// On a hit the scan stops at the first match.
// The palette RAM is read one entry per cycle through its registered read port.
// The next pixel is taken in the cycle after the result is loaded.
// Reset clears the entry count; the palette RAM itself is not cleared.
// A finished result waits in the scan state while the output register is still occupied.
`timescale 1ns / 1ps

module color_palette_index_builder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpib_pkg::t_pixel  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cpib_pkg::t_result o_out_data
);

    cpib_pkg::t_dp_cmd    cmd;
    cpib_pkg::t_dp_status status;

    cpib_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    cpib_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pixel    (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

`ifndef SYNTHESIS
    // The cycle after an accept is always spent searching, so no pixel is taken then.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again right after an accept");

    // A full-table error never comes with a stored entry.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.newly_added && o_out_data.table_full_error))
        else $error("newly_added and table_full_error both set");

    // An error word carries index zero and a null symbol.
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_full_error) |->
            (o_out_data.palette_index == '0 && o_out_data.symbol_code == cpib_pkg::SYM_NONE))
        else $error("error word has nonzero index or symbol");

    // Every valid non-error word has a printable symbol.
    a_symbol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.table_full_error) |->
            (o_out_data.symbol_code == cpib_pkg::SYM_SPACE ||
             o_out_data.symbol_code > cpib_pkg::SYM_BASE))
        else $error("symbol out of range for a valid entry");
`endif

endmodule
